// File: hdl/palette_color_to_rgb48_defines.svh
// assertion macros for the checker file
`ifndef PALETTE_COLOR_TO_RGB48_DEFINES_SVH
`define PALETTE_COLOR_TO_RGB48_DEFINES_SVH

// property checked only while out of reset
`define PCRGB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every edge, reset included
`define PCRGB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/pcrgb_pkg.sv
`default_nettype none

package pcrgb_pkg;

    localparam int CHAN_W  = 5;
    localparam int LEVEL_W = 4;
    localparam int INDEX_W = 19;
    localparam int OUT_W   = 16;
    localparam int GAMMA_W = 8;

    // field positions inside the palette value
    localparam int RED_LSB   = 0;
    localparam int GREEN_LSB = 5;
    localparam int BLUE_LSB  = 10;
    localparam int LEVEL_LSB = 15;

    localparam logic EMULATION_RESET = 1'b1;

    typedef logic [CHAN_W-1:0]  chan_t;
    typedef logic [LEVEL_W-1:0] level_t;
    typedef logic [INDEX_W-1:0] index_t;
    typedef logic [OUT_W-1:0]   intensity_t;
    typedef logic [GAMMA_W-1:0] gamma_t;

    // gamma ramp used in emulation mode
    function automatic gamma_t gamma_ramp(input chan_t c);
        gamma_t g;
        case (c)
            5'd0:    g = 8'h00;
            5'd1:    g = 8'h01;
            5'd2:    g = 8'h03;
            5'd3:    g = 8'h06;
            5'd4:    g = 8'h0a;
            5'd5:    g = 8'h0f;
            5'd6:    g = 8'h15;
            5'd7:    g = 8'h1c;
            5'd8:    g = 8'h24;
            5'd9:    g = 8'h2d;
            5'd10:   g = 8'h37;
            5'd11:   g = 8'h42;
            5'd12:   g = 8'h4e;
            5'd13:   g = 8'h5b;
            5'd14:   g = 8'h69;
            5'd15:   g = 8'h78;
            5'd16:   g = 8'h88;
            5'd17:   g = 8'h90;
            5'd18:   g = 8'h98;
            5'd19:   g = 8'ha0;
            5'd20:   g = 8'ha8;
            5'd21:   g = 8'hb0;
            5'd22:   g = 8'hb8;
            5'd23:   g = 8'hc0;
            5'd24:   g = 8'hc8;
            5'd25:   g = 8'hd0;
            5'd26:   g = 8'hd8;
            5'd27:   g = 8'he0;
            5'd28:   g = 8'he8;
            5'd29:   g = 8'hf0;
            5'd30:   g = 8'hf8;
            default: g = 8'hff;
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

// File: hdl/pcrgb_if.sv
`default_nettype none

// palette value channel
interface pcrgb_color_if;
    logic              valid;
    logic              ready;
    pcrgb_pkg::index_t color_index;

    modport source (output valid, output color_index, input ready);
    modport sink   (input valid, input color_index, output ready);
endinterface

// rgb result channel
interface pcrgb_rgb_if;
    logic                  valid;
    logic                  ready;
    pcrgb_pkg::intensity_t red_out;
    pcrgb_pkg::intensity_t green_out;
    pcrgb_pkg::intensity_t blue_out;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    output ready);
endinterface

// configuration write channel
interface pcrgb_cfg_if;
    logic valid;
    logic ready;
    logic color_emulation;

    modport source (output valid, output color_emulation, input ready);
    modport sink   (input valid, input color_emulation, output ready);
endinterface

`default_nettype wire

// File: hdl/pcrgb_chan.sv
`default_nettype none

module pcrgb_chan
(
    input  wire logic                  emulation,
    input  wire pcrgb_pkg::chan_t      chan,
    input  wire pcrgb_pkg::level_t     level,
    output pcrgb_pkg::intensity_t      value
);

    localparam int SCALE_W = pcrgb_pkg::LEVEL_W + 1;
    localparam int PROD_W  = pcrgb_pkg::OUT_W + SCALE_W;

    pcrgb_pkg::gamma_t     gamma;
    pcrgb_pkg::intensity_t wide;
    logic [SCALE_W-1:0]    scale;
    logic [PROD_W-1:0]     product;

    // widen to 16 bits: gamma entry times 0x0101, or bit repetition
    always_comb
    begin
        gamma = pcrgb_pkg::gamma_ramp(chan);
        if (emulation)
        begin
            wide = {gamma, gamma};
        end
        else
        begin
            wide = {chan, chan, chan, chan[pcrgb_pkg::CHAN_W-1]};
        end
    end

    // brightness: (l+1)/16, or 1/64 at level zero
    always_comb
    begin
        scale   = {1'b0, level} + SCALE_W'(1);
        product = PROD_W'(wide) * PROD_W'(scale);
        if (level == '0)
        begin
            value = {6'b0, wide[pcrgb_pkg::OUT_W-1:6]};
        end
        else
        begin
            value = product[pcrgb_pkg::OUT_W+3:4];
        end
    end

endmodule

`default_nettype wire

// File: hdl/palette_color_to_rgb48.sv
// a palette value passes the input register, then the result register, which loads it once the result side is free
// throughput: one palette value per cycle, no bubbles while the result side is ready
// the input register and the result register each move on when the next stage frees up
// reset clears both valid flags and sets color_emulation to 1 (gamma ramp)
// the configuration channel is always ready
`default_nettype none

module palette_color_to_rgb48
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    pcrgb_color_if.sink color,
    pcrgb_rgb_if.source rgb,
    pcrgb_cfg_if.sink   cfg
);

    logic                  emulation_reg;
    logic                  in_valid_reg;
    pcrgb_pkg::index_t     in_index_reg;
    logic                  out_valid_reg;
    pcrgb_pkg::intensity_t red_reg;
    pcrgb_pkg::intensity_t green_reg;
    pcrgb_pkg::intensity_t blue_reg;

    pcrgb_pkg::intensity_t red_next;
    pcrgb_pkg::intensity_t green_next;
    pcrgb_pkg::intensity_t blue_next;
    pcrgb_pkg::level_t     level;
    logic                  out_free;
    logic                  in_move;

    // configuration register
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emulation_reg <= pcrgb_pkg::EMULATION_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            emulation_reg <= cfg.color_emulation;
        end
    end

    // stage handshake
    assign out_free    = !out_valid_reg || rgb.ready;
    assign in_move     = in_valid_reg && out_free;
    assign color.ready = !in_valid_reg || out_free;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (color.ready)
        begin
            in_valid_reg <= color.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (color.valid && color.ready)
        begin
            in_index_reg <= color.color_index;
        end
    end

    // per channel conversion
    assign level = in_index_reg[pcrgb_pkg::LEVEL_LSB +: pcrgb_pkg::LEVEL_W];

    pcrgb_chan u_red
    (
        .emulation (emulation_reg),
        .chan      (in_index_reg[pcrgb_pkg::RED_LSB +: pcrgb_pkg::CHAN_W]),
        .level     (level),
        .value     (red_next)
    );

    pcrgb_chan u_green
    (
        .emulation (emulation_reg),
        .chan      (in_index_reg[pcrgb_pkg::GREEN_LSB +: pcrgb_pkg::CHAN_W]),
        .level     (level),
        .value     (green_next)
    );

    pcrgb_chan u_blue
    (
        .emulation (emulation_reg),
        .chan      (in_index_reg[pcrgb_pkg::BLUE_LSB +: pcrgb_pkg::CHAN_W]),
        .level     (level),
        .value     (blue_next)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_move)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign rgb.valid     = out_valid_reg;
    assign rgb.red_out   = red_reg;
    assign rgb.green_out = green_reg;
    assign rgb.blue_out  = blue_reg;

endmodule

`default_nettype wire

// File: hdl/pcrgb_check.sv
`default_nettype none
`include "palette_color_to_rgb48_defines.svh"

module pcrgb_check
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_valid,
    input wire logic                  in_ready,
    input wire logic                  out_valid,
    input wire logic                  out_ready,
    input wire pcrgb_pkg::intensity_t red_out,
    input wire pcrgb_pkg::intensity_t green_out,
    input wire pcrgb_pkg::intensity_t blue_out
);

    // a stalled result keeps valid and its data
    `PCRGB_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
    `PCRGB_ASSERT(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(red_out) && $stable(green_out) && $stable(blue_out), "result changed while stalled")
    // an empty result register never blocks the input
    `PCRGB_ASSERT(a_in_open, clk, rst_n, !out_valid |-> in_ready, "input blocked with empty result stage")
    // every transfer in is followed by a valid result on the output
    `PCRGB_ASSERT(a_latency, clk, rst_n, in_valid && in_ready |=> ##1 out_valid, "result missing after transfer")

endmodule

bind palette_color_to_rgb48 pcrgb_check u_pcrgb_check
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (color.valid),
    .in_ready  (color.ready),
    .out_valid (rgb.valid),
    .out_ready (rgb.ready),
    .red_out   (rgb.red_out),
    .green_out (rgb.green_out),
    .blue_out  (rgb.blue_out)
);

`default_nettype wire
